### sv/stp_pkg.sv
// Shared types, register indexes, reset values and the coil table of the
// stepper trapezoid sequencer. No dependencies; every other file imports it.
package stp_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 9;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_DELAY  = 3'd0,
    CFG_CRUISE_DELAY = 3'd1,
    CFG_QUARTER      = 3'd2,
    CFG_RAMP_END     = 3'd3,
    CFG_CRUISE_ONE   = 3'd4,
    CFG_CRUISE_TWO   = 3'd5,
    CFG_DECEL_ONE    = 3'd6,
    CFG_DECEL_TWO    = 3'd7
  } cfg_idx_e;

  // Command selector codes; the unused code acts as a tick
  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_MOVE = 2'd1,
    FUNC_HOME = 2'd2
  } func_e;

  // Sequencer run mode
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_HOME = 2'd2
  } mode_e;

  // Register reset values
  localparam logic [7:0] START_DELAY_RST  = 8'd20;
  localparam logic [7:0] CRUISE_DELAY_RST = 8'd5;
  localparam logic [7:0] QUARTER_RST      = 8'd50;
  localparam logic [8:0] RAMP_END_RST     = 9'd15;
  localparam logic [8:0] CRUISE_ONE_RST   = 9'd45;
  localparam logic [8:0] CRUISE_TWO_RST   = 9'd95;
  localparam logic [8:0] DECEL_ONE_RST    = 9'd43;
  localparam logic [8:0] DECEL_TWO_RST    = 9'd93;

  typedef struct packed {
    logic [7:0] start_delay_ms;
    logic [7:0] cruise_delay_ms;
    logic [7:0] quarter_steps;
    logic [8:0] ramp_end_step;
    logic [8:0] cruise_end_one;
    logic [8:0] cruise_end_two;
    logic [8:0] decel_base_one;
    logic [8:0] decel_base_two;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic       dir_cw;
    logic [1:0] quadrant_count;
    logic       hall_seen;
  } in_item_t;

  typedef struct packed {
    logic [5:0] phase_pattern;
    logic       phase_new;
    logic       busy_res;
    logic       done_res;
    logic       cmd_rejected;
  } out_item_t;

  // Coil drive pattern for each table slot
  function automatic logic [5:0] coil_pattern(input logic [1:0] slot);
    logic [5:0] pat;
    unique case (slot)
      2'd0: pat = 6'b110101;
      2'd1: pat = 6'b110110;
      2'd2: pat = 6'b101110;
      default: pat = 6'b101101;
    endcase
    return pat;
  endfunction

endpackage

### sv/stp_if.sv
// Handshake channel interfaces: tick items in, result items out, config writes.
// Depends on stp_pkg for the payload types.
interface stp_in_if import stp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stp_out_if import stp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stp_cfg_if import stp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

### sv/stp_cfg_regs.sv
// Configuration register file of the stepper sequencer.
// Depends on stp_pkg for register indexes, reset values and cfg_t.
module stp_cfg_regs import stp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the write into the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CFG_START_DELAY:  cfg_d.start_delay_ms  = wr_data_i[7:0];
        CFG_CRUISE_DELAY: cfg_d.cruise_delay_ms = wr_data_i[7:0];
        CFG_QUARTER:      cfg_d.quarter_steps   = wr_data_i[7:0];
        CFG_RAMP_END:     cfg_d.ramp_end_step   = wr_data_i;
        CFG_CRUISE_ONE:   cfg_d.cruise_end_one  = wr_data_i;
        CFG_CRUISE_TWO:   cfg_d.cruise_end_two  = wr_data_i;
        CFG_DECEL_ONE:    cfg_d.decel_base_one  = wr_data_i;
        CFG_DECEL_TWO:    cfg_d.decel_base_two  = wr_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_delay_ms  <= START_DELAY_RST;
      cfg_q.cruise_delay_ms <= CRUISE_DELAY_RST;
      cfg_q.quarter_steps   <= QUARTER_RST;
      cfg_q.ramp_end_step   <= RAMP_END_RST;
      cfg_q.cruise_end_one  <= CRUISE_ONE_RST;
      cfg_q.cruise_end_two  <= CRUISE_TWO_RST;
      cfg_q.decel_base_one  <= DECEL_ONE_RST;
      cfg_q.decel_base_two  <= DECEL_TWO_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/stp_seq.sv
// Step sequencer state and its per-tick update: command decode, step timing,
// trapezoid delay and coil pattern. Depends on stp_pkg.
module stp_seq import stp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  mode_e       mode_q, mode_d;
  logic [1:0]  phase_q, phase_d;
  logic        rev_q, rev_d;
  logic        two_q, two_d;
  logic [8:0]  idx_q, idx_d;
  logic [8:0]  total_q, total_d;
  logic [1:0]  base_q, base_d;
  logic [10:0] wait_q, wait_d;
  logic [5:0]  drive_q, drive_d;

  logic        apply;
  logic        stepped;
  logic        done;
  logic        rejected;
  logic        finish;
  logic        is_cmd;
  logic [1:0]  qc_sat;
  logic [1:0]  cur_slot;
  logic [1:0]  nxt_slot;
  logic [10:0] nxt_delay;
  logic [9:0]  idx_inc;

  // Table slot for an index under a given base and direction
  function automatic logic [1:0] slot_of(input logic [1:0] base, input logic [8:0] idx,
                                         input logic rev);
    logic [1:0] k;
    k = base + idx[1:0];
    return rev ? (2'd3 - k) : k;
  endfunction

  // Trapezoid delay of step idx
  function automatic logic [10:0] delay_of(input cfg_t cfg, input logic [8:0] idx,
                                           input logic two);
    logic [8:0]  cend;
    logic [8:0]  dbase;
    logic [8:0]  diff;
    logic [10:0] dly;
    cend  = two ? cfg.cruise_end_two : cfg.cruise_end_one;
    dbase = two ? cfg.decel_base_two : cfg.decel_base_one;
    diff  = idx - dbase;
    if (idx < cfg.ramp_end_step) begin
      dly = ({1'b0, cfg.start_delay_ms} > idx)
          ? {2'b00, ({1'b0, cfg.start_delay_ms} - idx)} : 11'd0;
    end else if (idx < cend) begin
      dly = {3'b000, cfg.cruise_delay_ms};
    end else begin
      dly = (idx > dbase) ? (({2'b00, diff} << 1) + {2'b00, diff}) : 11'd0;
    end
    return dly;
  endfunction

  assign is_cmd   = (item_i.func == FUNC_MOVE) || (item_i.func == FUNC_HOME);
  assign qc_sat   = (item_i.quadrant_count > 2'd2) ? 2'd2 : item_i.quadrant_count;
  assign idx_inc  = {1'b0, idx_q} + 10'd1;
  assign finish   = (mode_q == MODE_MOVE) ? (idx_inc >= {1'b0, total_q}) : item_i.hall_seen;
  assign cur_slot = slot_of(base_q, idx_q, rev_q);

  // Decode the command or advance the running step
  always_comb begin
    mode_d   = mode_q;
    phase_d  = phase_q;
    rev_d    = rev_q;
    two_d    = two_q;
    idx_d    = idx_q;
    total_d  = total_q;
    base_d   = base_q;
    apply    = 1'b0;
    done     = 1'b0;
    rejected = 1'b0;
    if (mode_q == MODE_IDLE) begin
      if (item_i.func == FUNC_MOVE) begin
        rev_d   = !item_i.dir_cw;
        two_d   = (qc_sat == 2'd2);
        base_d  = item_i.dir_cw ? (phase_q + 2'd1) : (2'd0 - phase_q);
        unique case (qc_sat)
          2'd2:    total_d = {cfg_i.quarter_steps, 1'b0};
          2'd1:    total_d = {1'b0, cfg_i.quarter_steps};
          default: total_d = 9'd0;
        endcase
        idx_d = 9'd0;
        if (total_d == 9'd0) begin
          done = 1'b1;
        end else begin
          mode_d = MODE_MOVE;
          apply  = 1'b1;
        end
      end else if (item_i.func == FUNC_HOME) begin
        rev_d  = 1'b0;
        base_d = phase_q + 2'd1;
        idx_d  = 9'd0;
        if (item_i.hall_seen) begin
          done = 1'b1;
        end else begin
          mode_d = MODE_HOME;
          apply  = 1'b1;
        end
      end
    end else begin
      rejected = is_cmd;
      if (wait_q <= 11'd1) begin
        if (finish) begin
          phase_d = cur_slot;
          mode_d  = MODE_IDLE;
          done    = 1'b1;
        end else begin
          idx_d = idx_inc[8:0];
          apply = 1'b1;
        end
      end
    end
  end

  // Pattern and hold time of a newly applied step
  assign nxt_slot  = slot_of(base_d, idx_d, rev_d);
  assign nxt_delay = delay_of(cfg_i, idx_d, two_d);
  assign stepped   = apply;

  always_comb begin
    drive_d = drive_q;
    wait_d  = wait_q;
    if (apply) begin
      drive_d = coil_pattern(nxt_slot);
      wait_d  = (mode_d == MODE_HOME) ? {3'b000, cfg_i.start_delay_ms} : nxt_delay;
    end else if (mode_q != MODE_IDLE) begin
      wait_d = (mode_d == MODE_IDLE) ? 11'd0 : (wait_q - 11'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      phase_q <= 2'd0;
      rev_q   <= 1'b0;
      two_q   <= 1'b0;
      idx_q   <= 9'd0;
      total_q <= 9'd0;
      base_q  <= 2'd0;
      wait_q  <= 11'd0;
      drive_q <= 6'd0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      rev_q   <= rev_d;
      two_q   <= two_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      base_q  <= base_d;
      wait_q  <= wait_d;
      drive_q <= drive_d;
    end
  end

  // Result of this tick
  always_comb begin
    res_o.phase_pattern = drive_d;
    res_o.phase_new     = stepped;
    res_o.busy_res      = (mode_d != MODE_IDLE);
    res_o.done_res      = done;
    res_o.cmd_rejected  = rejected;
  end

  // A tick never both steps and finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stepped && done))
    else $error("step and finish in one tick");

  // Commands are only rejected while running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && rejected) |-> (mode_q != MODE_IDLE))
    else $error("command rejected while idle");

  // No pending hold time while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE) |-> (wait_q == 11'd0))
    else $error("hold time left while idle");

  // A move never runs past its step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_MOVE) |-> (idx_q < total_q))
    else $error("step index beyond move length");

endmodule

### sv/stp_out_buf.sv
// Two-entry result buffer (output register plus skid register) that lets the
// sequencer take a tick while a result still waits. Depends on stp_pkg.
module stp_out_buf import stp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t data_i,
  output logic      ready_o,
  output logic      valid_o,
  output out_item_t data_o,
  input  logic      ready_i
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_q;
  out_item_t skid_q;
  logic      pop;
  logic      head_free;

  assign pop       = out_valid_q && ready_i;
  assign head_free = pop || !out_valid_q;
  assign ready_o   = !skid_valid_q;
  assign valid_o   = out_valid_q;
  assign data_o    = out_q;

  // Refill the head from the skid stage first, then from the new item
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (head_free) begin
      out_valid_d  = skid_valid_q || push_i;
      skid_valid_d = skid_valid_q && push_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (head_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push_i) begin
          skid_q <= data_i;
        end
      end else if (push_i) begin
        out_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  // The skid stage only fills behind a full head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid item without head item");

endmodule

### sv/stepper_trapezoid_sequencer_core.sv
// Full-step stepper sequencer with trapezoidal ramp, one tick item per cycle
// while the result buffer has room; a tick's result is registered in that buffer
// (output or skid register). The state update is a single pass of compare,
// decrement and table logic, and a two-entry result buffer decouples.
// Reset: registers load their defaults, sequencer idle at slot zero, buffer
// empty; no clearing pass. Depends on stp_pkg, stp_if and the stp_* modules.
module stepper_trapezoid_sequencer_core import stp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  stp_in_if.sink         in_i,
  stp_out_if.source      out_o,
  stp_cfg_if.sink        cfg_i
);

  cfg_t      cfg;
  out_item_t res;
  logic      buf_ready;
  logic      fire;

  // Config writes are always taken
  assign cfg_i.ready = 1'b1;

  // Accept a tick whenever the result buffer has room
  assign in_i.ready = buf_ready;
  assign fire       = in_i.valid && buf_ready;

  stp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.reg_index),
    .wr_data_i  (cfg_i.wdata),
    .cfg_o      (cfg)
  );

  stp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_i.data),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  stp_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .data_i  (res),
    .ready_o (buf_ready),
    .valid_o (out_o.valid),
    .data_o  (out_o.data),
    .ready_i (out_o.ready)
  );

endmodule
